### hdl/assert_macros.svh
// Assertion helpers used by transfer_encoding_decoder.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/tedec_pkg.sv
package tedec_pkg;

   // Decode mode register.
   localparam int MODE_W = 2;
   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_PASS   = 2'd0;
   localparam mode_type MODE_BASE64 = 2'd1;
   localparam mode_type MODE_QP     = 2'd2;

   // Most results one item can cause.
   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       run_last;
      logic       data_end;
   } rsp_type;

   // All results of one item, slot 0 first, plus how many are valid.
   typedef struct packed {
      logic [1:0]                  num;
      rsp_type [MAX_RESULTS-1:0]   slot;
   } grp_type;

endpackage

### hdl/tedec_step.sv
module tedec_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  tedec_pkg::req_type item,
   input  tedec_pkg::mode_type mode,
   output tedec_pkg::grp_type grp
);
   import tedec_pkg::*;

   localparam logic [7:0] CHAR_EQ = 8'h3D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef enum logic [1:0] {
      ESC_IDLE = 2'd0,
      ESC_EQ   = 2'd1,
      ESC_HEX  = 2'd2
   } esc_type;

   // Bit 6 set means the byte is not in the base64 alphabet.
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = 7'h40;
      if (c inside {[8'h41:8'h5A]}) r = {1'b0, 6'(c - 8'd65)};
      else if (c inside {[8'h61:8'h7A]}) r = {1'b0, 6'(c - 8'd71)};
      else if (c inside {[8'h30:8'h39]}) r = {1'b0, 6'(c + 8'd4)};
      else if (c == 8'h2B) r = {1'b0, 6'd62};
      else if (c == 8'h2F) r = {1'b0, 6'd63};
      return r;
   endfunction

   // Bit 4 set means the byte is a hex digit.
   function automatic logic [4:0] hex_of(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h00;
      if (c inside {[8'h30:8'h39]}) r = {1'b1, 4'(c - 8'd48)};
      else if (c inside {[8'h61:8'h66]}) r = {1'b1, 4'(c - 8'd87)};
      else if (c inside {[8'h41:8'h46]}) r = {1'b1, 4'(c - 8'd55)};
      return r;
   endfunction

   esc_type     esc_ff, esc_in;
   logic [7:0]  held_ff, held_in;
   logic [11:0] acc_ff, acc_in;
   logic [3:0]  bits_ff, bits_in;

   logic [MAX_RESULTS-1:0][7:0] pbytes;
   logic [1:0]  pn;
   logic [7:0]  c;
   logic        fin;
   logic [6:0]  sx;
   logic [4:0]  hx;
   logic [4:0]  hh;
   logic [11:0] acc_cat;
   logic [3:0]  bits_sum;
   logic [3:0]  sh;
   logic        do_fresh;

   always_comb begin
      c        = item.data_byte;
      fin      = item.final_byte;
      sx       = sextet_of(c);
      hx       = hex_of(c);
      hh       = hex_of(held_ff);
      acc_cat  = {acc_ff[5:0], sx[5:0]};
      bits_sum = bits_ff + 4'd6;
      sh       = bits_sum - 4'd8;
      esc_in   = esc_ff;
      held_in  = held_ff;
      acc_in   = acc_ff;
      bits_in  = bits_ff;
      pbytes   = '0;
      pn       = 2'd0;
      do_fresh = 1'b0;

      case (mode)
         MODE_BASE64: begin
            if (!sx[6]) begin
               acc_in = acc_cat;
               if (bits_sum >= 4'd8) begin
                  pbytes[0] = 8'(acc_cat >> sh);
                  pn        = 2'd1;
                  bits_in   = sh;
               end else begin
                  bits_in = bits_sum;
               end
            end
         end
         MODE_QP: begin
            case (esc_ff)
               ESC_EQ: begin
                  if (c == CHAR_LF) begin
                     esc_in = ESC_IDLE;
                  end else if (hx[4]) begin
                     held_in = c;
                     esc_in  = ESC_HEX;
                  end else begin
                     esc_in    = ESC_IDLE;
                     pbytes[0] = CHAR_EQ;
                     pn        = 2'd1;
                     do_fresh  = 1'b1;
                  end
               end
               ESC_HEX: begin
                  esc_in  = ESC_IDLE;
                  held_in = 8'h00;
                  if (hh[4] && hx[4]) begin
                     pbytes[0] = {hh[3:0], hx[3:0]};
                     pn        = 2'd1;
                  end else begin
                     pbytes[0] = CHAR_EQ;
                     pbytes[1] = held_ff;
                     pn        = 2'd2;
                     do_fresh  = 1'b1;
                  end
               end
               default: begin
                  esc_in   = ESC_IDLE;
                  do_fresh = 1'b1;
               end
            endcase

            if (do_fresh) begin
               if (c == CHAR_EQ) begin
                  esc_in = ESC_EQ;
               end else if (pn != 2'd3) begin
                  pbytes[pn] = c;
                  pn         = pn + 2'd1;
               end
            end

            // An escape still open at the end of data comes out literally.
            if (fin && esc_in != ESC_IDLE) begin
               if (pn != 2'd3) begin
                  pbytes[pn] = CHAR_EQ;
                  pn         = pn + 2'd1;
               end
               if (esc_in == ESC_HEX && pn != 2'd3) begin
                  pbytes[pn] = held_in;
                  pn         = pn + 2'd1;
               end
            end
         end
         default: begin
            pbytes[0] = c;
            pn        = 2'd1;
         end
      endcase

      if (fin) begin
         esc_in  = ESC_IDLE;
         held_in = 8'h00;
         acc_in  = 12'h000;
         bits_in = 4'd0;
      end
   end

   always_comb begin
      grp = '0;
      if (pn == 2'd0) begin
         grp.num = fin ? 2'd1 : 2'd0;
         grp.slot[0].run_last = 1'b1;
         grp.slot[0].data_end = 1'b1;
      end else begin
         grp.num = pn;
         for (int k = 0; k < MAX_RESULTS; k++) begin
            grp.slot[k].out_byte     = pbytes[k];
            grp.slot[k].byte_present = 1'b1;
            grp.slot[k].run_last     = (2'(k) == pn - 2'd1);
            grp.slot[k].data_end     = (2'(k) == pn - 2'd1) && fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff  <= ESC_IDLE;
         held_ff <= 8'h00;
         acc_ff  <= 12'h000;
         bits_ff <= 4'd0;
      end else if (accept) begin
         esc_ff  <= esc_in;
         held_ff <= held_in;
         acc_ff  <= acc_in;
         bits_ff <= bits_in;
      end
   end

endmodule

### hdl/transfer_encoding_decoder.sv
// The first result of an item is offered in the cycle after the item is accepted.
// One item per cycle while each item causes at most one result and rsp_stall stays low;
// an item that causes n results holds the single result port, and the next item is
// taken only as its last result leaves. Reset is synchronous and active high: the mode
// returns to pass-through, all decode state clears and the result buffer empties.
`include "assert_macros.svh"

module transfer_encoding_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tedec_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tedec_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  tedec_pkg::mode_type csr_wdata
);
   import tedec_pkg::*;

   // The mode register. Writes are always taken; the user must write it only while the
   // block is idle, so no item sees a mode change in flight. The block does not enforce this.
   mode_type mode_ff, mode_in;

   // Result buffer: up to three results of one item, slot 0 is the one on
   // offer. rem_ff counts the results still waiting to be taken.
   logic [1:0]                rem_ff, rem_in;
   rsp_type [MAX_RESULTS-1:0] slot_ff, slot_in;

   grp_type grp;
   logic    accept;
   logic    take;

   assign csr_ready = 1'b1;

   assign rsp_valid = (rem_ff != 2'd0);
   assign rsp_data  = slot_ff[0];
   assign take      = rsp_valid && !rsp_stall;

   // A new item is taken when the buffer is empty, or when its last result
   // leaves in this very cycle, so single-result items stream at full rate.
   assign req_stall = !((rem_ff == 2'd0) || (rem_ff == 2'd1 && take));
   assign accept    = req_valid && !req_stall;

   // The decoder computes every result of the item in one pass and updates
   // the base64 and quoted-printable state when the item is accepted.
   tedec_step u_step (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_data),
      .mode   (mode_ff),
      .grp    (grp)
   );

   always_comb begin
      mode_in = csr_valid ? csr_wdata : mode_ff;
      rem_in  = rem_ff;
      slot_in = slot_ff;
      if (accept) begin
         // The results of the new item replace the buffer. If a result left
         // in this cycle, it was the last one of the previous item.
         rem_in  = grp.num;
         slot_in = grp.slot;
      end else if (take) begin
         // Move the remaining results one place toward the output.
         rem_in     = rem_ff - 2'd1;
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PASS;
         rem_ff  <= 2'd0;
      end else begin
         mode_ff <= mode_in;
         rem_ff  <= rem_in;
      end
   end

   // The buffered results carry no control meaning on their own.
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // A final item always leaves at least one result behind it.
   `ASSERT_NEXT(a_final_gives_result, clock, reset,
      req_valid && !req_stall && req_data.final_byte, rem_ff != 2'd0)
   // The end of data is always the last result of its item.
   `ASSERT_IMPLIES(a_end_is_last, clock, reset,
      rsp_valid && rsp_data.data_end, rsp_data.run_last)
   // A result that is not the last of its item has a sibling behind it.
   `ASSERT_IMPLIES(a_more_follow, clock, reset,
      rsp_valid && !rsp_data.run_last, rem_ff >= 2'd2)
   // An end marker without data stands alone and closes the data.
   `ASSERT_IMPLIES(a_marker_alone, clock, reset,
      rsp_valid && !rsp_data.byte_present,
      rsp_data.data_end && rem_ff == 2'd1 && rsp_data.out_byte == 8'h00)

endmodule
